/* hw/rtl/rsi_pkg.sv */
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared widths, side-band types and saturation helper for the ray/sphere core
// ----------------------------------------------------------------------------
`default_nettype none

package rsi_pkg;

    localparam int COORD_BITS  = 32;
    localparam int FRAC_BITS   = 16;
    localparam int RADIUS_BITS = COORD_BITS - 1;

    // eye minus center, one bit wider than a coordinate
    localparam int O_W    = COORD_BITS + 1;
    localparam int A_W    = 2 * COORD_BITS;
    localparam int OD_W   = O_W + COORD_BITS;
    localparam int OO_W   = 2 * O_W;
    localparam int BH_W   = 2 * COORD_BITS + 2;
    localparam int CC_W   = 2 * COORD_BITS + 3;

    // wide multiplier is built from 2x2 limbs
    localparam int LIMB_W = COORD_BITS + 2;
    localparam int MUL_W  = 2 * LIMB_W;
    localparam int PROD_W = 2 * MUL_W;
    localparam int Q_W    = PROD_W + 2;

    // square root of the discriminant scaled by 2^(2*frac)
    localparam int RAD_W     = PROD_W + 2 * FRAC_BITS;
    localparam int ROOT_W    = RAD_W / 2;
    localparam int REM_W     = ROOT_W + 2;
    localparam int SQ_STAGES = ROOT_W;

    // numerator and quotient of the lambda divide
    localparam int N_W  = ROOT_W + 2;
    localparam int QB   = COORD_BITS + 1;
    localparam int QS_W = QB + 2;

    localparam int SAT_W = 2 * COORD_BITS;

    localparam int IN_DATA_W  = ((9 * COORD_BITS + RADIUS_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((4 * COORD_BITS + 7) / 8) * 8;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [O_W-1:0]        ofs_t;

    typedef struct packed {
        logic                   nohit;
        logic [A_W-1:0]         a;
        logic signed [BH_W-1:0] bh;
        ofs_t [2:0]             o;
        coord_t [2:0]           d;
    } side_t;

    typedef struct packed {
        logic   hit;
        coord_t lambda;
        coord_t hx;
        coord_t hy;
        coord_t hz;
    } res_t;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic signed [SAT_W-1:0] SAT_HI =
        {{(SAT_W-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [SAT_W-1:0] SAT_LO = ~SAT_HI;

    function automatic coord_t sat_coord(input logic signed [SAT_W-1:0] v);
        coord_t r;
        if (v > SAT_HI) begin
            r = COORD_MAX;
        end else if (v < SAT_LO) begin
            r = COORD_MIN;
        end else begin
            r = v[COORD_BITS-1:0];
        end
        return r;
    endfunction

    localparam coord_t MINUS_ONE = sat_coord(-(SAT_W'(1) << FRAC_BITS));

endpackage

`default_nettype wire

/* hw/rtl/rsi_mul.sv */
// ----------------------------------------------------------------------------
// rsi_mul
// Two-stage unsigned wide multiplier: limb products, then one summing add
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_mul
    import rsi_pkg::*;
(
    input  logic              aclk,
    input  logic              en,
    input  logic [MUL_W-1:0]  x,
    input  logic [MUL_W-1:0]  y,
    output logic [PROD_W-1:0] p
);

    logic [MUL_W-1:0]  pp00_reg, pp01_reg, pp10_reg, pp11_reg;
    logic [MUL_W-1:0]  pp00_next, pp01_next, pp10_next, pp11_next;
    logic [PROD_W-1:0] p_reg, p_next;
    logic [LIMB_W-1:0] xl, xh, yl, yh;

    assign xl = x[LIMB_W-1:0];
    assign xh = x[MUL_W-1:LIMB_W];
    assign yl = y[LIMB_W-1:0];
    assign yh = y[MUL_W-1:LIMB_W];

    assign pp00_next = MUL_W'(xl) * MUL_W'(yl);
    assign pp01_next = MUL_W'(xl) * MUL_W'(yh);
    assign pp10_next = MUL_W'(xh) * MUL_W'(yl);
    assign pp11_next = MUL_W'(xh) * MUL_W'(yh);

    assign p_next = PROD_W'(pp00_reg)
                  + ((PROD_W'(pp01_reg) + PROD_W'(pp10_reg)) << LIMB_W)
                  + (PROD_W'(pp11_reg) << MUL_W);

    always_ff @(posedge aclk) begin
        if (en) begin
            pp00_reg <= pp00_next;
            pp01_reg <= pp01_next;
            pp10_reg <= pp10_next;
            pp11_reg <= pp11_next;
            p_reg    <= p_next;
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

/* hw/rtl/rsi_sqrt.sv */
// ----------------------------------------------------------------------------
// rsi_sqrt
// Pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_sqrt
    import rsi_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              vld_in,
    input  side_t             side_in,
    input  logic [RAD_W-1:0]  rad_in,
    output logic              vld_out,
    output side_t             side_out,
    output logic [ROOT_W-1:0] root_out
);

    logic              vld_reg  [SQ_STAGES];
    side_t             side_reg [SQ_STAGES];
    logic [RAD_W-1:0]  rad_reg  [SQ_STAGES];
    logic [REM_W-1:0]  rem_reg  [SQ_STAGES];
    logic [ROOT_W-1:0] root_reg [SQ_STAGES];

    genvar k;
    for (k = 0; k < SQ_STAGES; k++) begin : g_st
        logic              vld_prev;
        side_t             side_prev;
        logic [RAD_W-1:0]  rad_prev;
        logic [REM_W-1:0]  rem_prev;
        logic [ROOT_W-1:0] root_prev;
        logic [REM_W-1:0]  rem_sh, trial, rem_next;
        logic              ge;

        if (k == 0) begin : g_first
            assign vld_prev  = vld_in;
            assign side_prev = side_in;
            assign rad_prev  = rad_in;
            assign rem_prev  = '0;
            assign root_prev = '0;
        end else begin : g_rest
            assign vld_prev  = vld_reg[k-1];
            assign side_prev = side_reg[k-1];
            assign rad_prev  = rad_reg[k-1];
            assign rem_prev  = rem_reg[k-1];
            assign root_prev = root_reg[k-1];
        end

        // bring down the next two radicand bits and try 4*root+1
        assign rem_sh   = {rem_prev[REM_W-3:0], rad_prev[RAD_W-1 -: 2]};
        assign trial    = {root_prev, 2'b01};
        assign ge       = rem_sh >= trial;
        assign rem_next = ge ? rem_sh - trial : rem_sh;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[k] <= side_prev;
                rad_reg[k]  <= rad_prev << 2;
                rem_reg[k]  <= rem_next;
                root_reg[k] <= {root_prev[ROOT_W-2:0], ge};
            end
        end
    end

    assign vld_out  = vld_reg[SQ_STAGES-1];
    assign side_out = side_reg[SQ_STAGES-1];
    assign root_out = root_reg[SQ_STAGES-1];

endmodule

`default_nettype wire

/* hw/rtl/rsi_div.sv */
// ----------------------------------------------------------------------------
// rsi_div
// Pipelined restoring divide of the root numerator by |dir|^2, floored and
// saturated to a coordinate
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_div
    import rsi_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           vld_in,
    input  side_t          side_in,
    input  logic [N_W-1:0] n_mag,
    input  logic           n_neg,
    output logic           vld_out,
    output side_t          side_out,
    output coord_t         lam_out
);

    logic           vld_reg  [QB+1];
    side_t          side_reg [QB+1];
    logic [A_W-1:0] r_reg    [QB+1];
    logic [QB-1:0]  lo_reg   [QB+1];
    logic [QB-1:0]  q_reg    [QB+1];
    logic           ovf_reg  [QB+1];
    logic           neg_reg  [QB+1];

    logic [N_W-1:0] hi;
    logic           ovf_next;

    logic           vo_reg;
    side_t          so_reg;
    coord_t         lam_reg, lam_next;
    logic signed [QS_W-1:0] qs;

    // quotient would need more than QB bits: saturate
    assign hi       = n_mag >> QB;
    assign ovf_next = hi >= N_W'(side_in.a);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= vld_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_in;
            r_reg[0]    <= hi[A_W-1:0];
            lo_reg[0]   <= n_mag[QB-1:0];
            q_reg[0]    <= '0;
            ovf_reg[0]  <= ovf_next;
            neg_reg[0]  <= n_neg;
        end
    end

    genvar k;
    for (k = 1; k <= QB; k++) begin : g_st
        logic [A_W:0] r_sh, dv, r_sub;
        logic         ge;

        assign r_sh  = {r_reg[k-1], lo_reg[k-1][QB-1]};
        assign dv    = {1'b0, side_reg[k-1].a};
        assign ge    = r_sh >= dv;
        assign r_sub = r_sh - dv;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[k] <= side_reg[k-1];
                r_reg[k]    <= ge ? r_sub[A_W-1:0] : r_sh[A_W-1:0];
                lo_reg[k]   <= lo_reg[k-1] << 1;
                q_reg[k]    <= {q_reg[k-1][QB-2:0], ge};
                ovf_reg[k]  <= ovf_reg[k-1];
                neg_reg[k]  <= neg_reg[k-1];
            end
        end
    end

    // floor for a negative numerator: round the magnitude quotient away from zero
    always_comb begin
        if (neg_reg[QB]) begin
            qs = -$signed({2'b00, q_reg[QB]}) - QS_W'(|r_reg[QB]);
        end else begin
            qs = $signed({2'b00, q_reg[QB]});
        end
        if (ovf_reg[QB]) begin
            lam_next = neg_reg[QB] ? COORD_MIN : COORD_MAX;
        end else begin
            lam_next = sat_coord(SAT_W'(qs));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vo_reg <= 1'b0;
        end else if (en) begin
            vo_reg <= vld_reg[QB];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            so_reg  <= side_reg[QB];
            lam_reg <= lam_next;
        end
    end

    assign vld_out  = vo_reg;
    assign side_out = so_reg;
    assign lam_out  = lam_reg;

endmodule

`default_nettype wire

/* hw/rtl/ray_sphere_intersect_core.sv */
// ----------------------------------------------------------------------------
// ray_sphere_intersect_core
// Fixed-point ray/sphere test: nearer root lambda and hit point per request
// ----------------------------------------------------------------------------
//  port group  dir  contents
//  s_t*        in   eye, direction, center (Q16.16), radius
//  m_t*        out  lambda and hit point (tdata), hit flag (tuser)
//
//  one request per cycle while the output is not stalled; most of the depth
//  at Q16.16 comes from the bit-per-stage square root and divide pipelines
//  reset (aresetn low, synchronous) drops every request in flight
//  an output stall first fills a one-entry skid register, then holds the pipe
// ----------------------------------------------------------------------------
`default_nettype none

module ray_sphere_intersect_core
    import rsi_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // eye_x, eye_y, eye_z, dir_x, dir_y, dir_z, center_x, center_y, center_z,
    // radius, zero pad
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // lambda, hit_x, hit_y, hit_z
    output logic [OUT_DATA_W-1:0] m_tdata,
    // hit
    output logic                  m_tuser
);

    logic en;

    // ---- stage 0: input, move eye into sphere coordinates
    coord_t [2:0] eye, dir, ctr;
    logic [RADIUS_BITS-1:0] radius;
    ofs_t [2:0] o_next;

    logic                   v0_reg;
    ofs_t [2:0]             o0_reg;
    coord_t [2:0]           d0_reg;
    logic [RADIUS_BITS-1:0] r0_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            eye[i]    = s_tdata[i*COORD_BITS +: COORD_BITS];
            dir[i]    = s_tdata[(3+i)*COORD_BITS +: COORD_BITS];
            ctr[i]    = s_tdata[(6+i)*COORD_BITS +: COORD_BITS];
            o_next[i] = ofs_t'($signed(eye[i])) - ofs_t'($signed(ctr[i]));
        end
    end
    assign radius = s_tdata[9*COORD_BITS +: RADIUS_BITS];

    // ---- stage 1: products
    logic signed [A_W-1:0]  dd_next [3];
    logic signed [OD_W-1:0] od_next [3];
    logic signed [OO_W-1:0] oo_next [3];
    logic [2*RADIUS_BITS-1:0] rr_next;

    logic                   v1_reg;
    logic signed [A_W-1:0]  dd_reg [3];
    logic signed [OD_W-1:0] od_reg [3];
    logic signed [OO_W-1:0] oo_reg [3];
    logic [2*RADIUS_BITS-1:0] rr_reg;
    ofs_t [2:0]             o1_reg;
    coord_t [2:0]           d1_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dd_next[i] = $signed(d0_reg[i]) * $signed(d0_reg[i]);
            od_next[i] = $signed(o0_reg[i]) * $signed(d0_reg[i]);
            oo_next[i] = $signed(o0_reg[i]) * $signed(o0_reg[i]);
        end
    end
    assign rr_next = (2*RADIUS_BITS)'(r0_reg) * (2*RADIUS_BITS)'(r0_reg);

    // ---- stage 2: quadratic coefficients
    logic [A_W-1:0]         a_next;
    logic signed [BH_W-1:0] bh_next;
    logic signed [CC_W-1:0] cc_next;

    logic                   v2_reg;
    logic [A_W-1:0]         a2_reg;
    logic signed [BH_W-1:0] bh2_reg;
    logic signed [CC_W-1:0] cc2_reg;
    ofs_t [2:0]             o2_reg;
    coord_t [2:0]           d2_reg;

    assign a_next  = A_W'(dd_reg[0] + dd_reg[1] + dd_reg[2]);
    assign bh_next = BH_W'(od_reg[0]) + BH_W'(od_reg[1]) + BH_W'(od_reg[2]);
    assign cc_next = CC_W'(oo_reg[0]) + CC_W'(oo_reg[1]) + CC_W'(oo_reg[2])
                   - $signed({1'b0, rr_reg});

    // ---- stages 3-4: b'^2 and a*c through the limb multipliers
    logic signed [MUL_W-1:0] bh_ext, cc_ext;
    logic [MUL_W-1:0]  bh_mag, cc_mag;
    logic [PROD_W-1:0] bb_prod, ac_prod;
    side_t side2;

    logic  v3_reg, v4_reg;
    side_t side3_reg, side4_reg;
    logic  ccn3_reg, ccn4_reg;

    assign bh_ext = MUL_W'(bh2_reg);
    assign cc_ext = MUL_W'(cc2_reg);
    assign bh_mag = bh2_reg[BH_W-1] ? -bh_ext : bh_ext;
    assign cc_mag = cc2_reg[CC_W-1] ? -cc_ext : cc_ext;

    always_comb begin
        side2.nohit = (a2_reg == '0);
        side2.a     = a2_reg;
        side2.bh    = bh2_reg;
        side2.o     = o2_reg;
        side2.d     = d2_reg;
    end

    rsi_mul u_mul_bb (
        .aclk (aclk),
        .en   (en),
        .x    (bh_mag),
        .y    (bh_mag),
        .p    (bb_prod)
    );

    rsi_mul u_mul_ac (
        .aclk (aclk),
        .en   (en),
        .x    (MUL_W'(a2_reg)),
        .y    (cc_mag),
        .p    (ac_prod)
    );

    // ---- stage 5: discriminant and radicand
    logic [Q_W-1:0]   q_next;
    logic             nohit5_next;
    logic [RAD_W-1:0] rad_next;
    side_t            side5_next;

    logic             v5_reg;
    side_t            side5_reg;
    logic [RAD_W-1:0] rad5_reg;

    always_comb begin
        if (ccn4_reg) begin
            q_next = Q_W'(bb_prod) + Q_W'(ac_prod);
        end else begin
            q_next = Q_W'(bb_prod) - Q_W'(ac_prod);
        end
        nohit5_next       = side4_reg.nohit || q_next[Q_W-1];
        side5_next        = side4_reg;
        side5_next.nohit  = nohit5_next;
        rad_next = nohit5_next ? '0 : {q_next[PROD_W-1:0], {(2*FRAC_BITS){1'b0}}};
    end

    // ---- square root
    logic              vs_out;
    side_t             sides_out;
    logic [ROOT_W-1:0] root;

    rsi_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .vld_in   (v5_reg),
        .side_in  (side5_reg),
        .rad_in   (rad5_reg),
        .vld_out  (vs_out),
        .side_out (sides_out),
        .root_out (root)
    );

    // ---- stage 6: numerator -b'*2^f - s
    logic signed [N_W-1:0] n_next;
    logic [N_W-1:0]        nmag_next;

    logic           v6_reg;
    side_t          side6_reg;
    logic [N_W-1:0] nmag6_reg;
    logic           nneg6_reg;

    assign n_next    = -(N_W'(sides_out.bh) <<< FRAC_BITS) - $signed(N_W'(root));
    assign nmag_next = n_next[N_W-1] ? -n_next : n_next;

    // ---- divide
    logic   vd_out;
    side_t  sided_out;
    coord_t lam;

    rsi_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .vld_in   (v6_reg),
        .side_in  (side6_reg),
        .n_mag    (nmag6_reg),
        .n_neg    (nneg6_reg),
        .vld_out  (vd_out),
        .side_out (sided_out),
        .lam_out  (lam)
    );

    // ---- stage 7: lambda * dir
    logic signed [SAT_W-1:0] ld_next [3];

    logic                    v7_reg;
    logic signed [SAT_W-1:0] ld7_reg [3];
    coord_t                  lam7_reg;
    logic                    nohit7_reg;
    ofs_t [2:0]              o7_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ld_next[i] = $signed(lam) * $signed(sided_out.d[i]);
        end
    end

    // ---- stage 8: hit point and result assembly
    coord_t h_next [3];
    res_t   res_next;

    logic p_valid_reg;
    res_t p_res_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            h_next[i] = sat_coord((ld7_reg[i] >>> FRAC_BITS) + SAT_W'($signed(o7_reg[i])));
        end
        res_next.hit    = !nohit7_reg;
        res_next.lambda = nohit7_reg ? MINUS_ONE : lam7_reg;
        res_next.hx     = nohit7_reg ? '0 : h_next[0];
        res_next.hy     = nohit7_reg ? '0 : h_next[1];
        res_next.hz     = nohit7_reg ? '0 : h_next[2];
    end

    // ---- pipeline registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg      <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            v6_reg      <= 1'b0;
            v7_reg      <= 1'b0;
            p_valid_reg <= 1'b0;
        end else if (en) begin
            v0_reg      <= s_tvalid;
            v1_reg      <= v0_reg;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            v4_reg      <= v3_reg;
            v5_reg      <= v4_reg;
            v6_reg      <= vs_out;
            v7_reg      <= vd_out;
            p_valid_reg <= v7_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            o0_reg <= o_next;
            d0_reg <= dir;
            r0_reg <= radius;

            for (int i = 0; i < 3; i++) begin
                dd_reg[i]  <= dd_next[i];
                od_reg[i]  <= od_next[i];
                oo_reg[i]  <= oo_next[i];
                ld7_reg[i] <= ld_next[i];
            end
            rr_reg <= rr_next;
            o1_reg <= o0_reg;
            d1_reg <= d0_reg;

            a2_reg  <= a_next;
            bh2_reg <= bh_next;
            cc2_reg <= cc_next;
            o2_reg  <= o1_reg;
            d2_reg  <= d1_reg;

            side3_reg <= side2;
            ccn3_reg  <= cc2_reg[CC_W-1];
            side4_reg <= side3_reg;
            ccn4_reg  <= ccn3_reg;

            side5_reg <= side5_next;
            rad5_reg  <= rad_next;

            side6_reg <= sides_out;
            nmag6_reg <= nmag_next;
            nneg6_reg <= n_next[N_W-1];

            lam7_reg   <= lam;
            nohit7_reg <= sided_out.nohit;
            o7_reg     <= sided_out.o;

            p_res_reg <= res_next;
        end
    end

    // ---- output register with one-entry skid
    logic out_valid_reg, out_valid_next;
    logic skid_valid_reg, skid_valid_next;
    res_t out_res_reg, out_res_next;
    res_t skid_res_reg, skid_res_next;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_res_next    = out_res_reg;
        skid_valid_next = skid_valid_reg;
        skid_res_next   = skid_res_reg;
        if (out_valid_reg && m_tready) begin
            if (skid_valid_reg) begin
                out_res_next    = skid_res_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = 1'b0;
            end
        end
        if (en && p_valid_reg) begin
            if (!out_valid_reg || m_tready) begin
                out_valid_next = 1'b1;
                out_res_next   = p_res_reg;
            end else begin
                skid_valid_next = 1'b1;
                skid_res_next   = p_res_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.hit;
    assign m_tdata  = OUT_DATA_W'({out_res_reg.hz, out_res_reg.hy,
                                   out_res_reg.hx, out_res_reg.lambda});

    // ---- checks
    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output register");

    a_miss_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_res_reg.hit) |->
        (out_res_reg.lambda == MINUS_ONE && out_res_reg.hx == '0 &&
         out_res_reg.hy == '0 && out_res_reg.hz == '0))
        else $error("miss result carries nonzero hit point or wrong lambda");

    a_skid_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && m_tready) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid entry not moved to output");

    a_stall_to_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && p_valid_reg && out_valid_reg && !m_tready) |=> skid_valid_reg)
        else $error("result lost on output stall");

endmodule

`default_nettype wire

/* tb/sv/tb_ray_sphere_intersect_core.sv */
// ----------------------------------------------------------------------------
// tb_ray_sphere_intersect_core
// Self-checking bench for the fixed-point ray/sphere core: exact wide-integer
// prediction of each request, random back-pressure and gaps on both sides
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_ray_sphere_intersect_core;
    import rsi_pkg::*;

    localparam int CLK_PERIOD = 8;
    localparam int LATENCY    = SQ_STAGES + QB + 12;
    localparam int CYCLE_CAP  = 400000;

    typedef logic signed [255:0] big_t;

    typedef struct {
        coord_t eye[3];
        coord_t dir[3];
        coord_t ctr[3];
        logic [RADIUS_BITS-1:0] radius;
    } ray_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;

    res_t   pending_hits[$];
    int     fail_count;
    int     sent_count;
    int     recv_count;
    int     hit_count;
    int     cycle_count;
    bit     src_idle_en;
    bit     sink_idle_en;
    int     sink_hold;

    ray_sphere_intersect_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // floor square root by bit-per-step
    function automatic big_t isqrt_floor(input big_t num);
        big_t res;
        big_t bit_v;
        big_t t;
        res = 0;
        bit_v = big_t'(1) <<< 252;
        while (bit_v != 0) begin
            t = res + bit_v;
            if (num >= t) begin
                num = num - t;
                res = (res >>> 1) + bit_v;
            end else begin
                res = res >>> 1;
            end
            bit_v = bit_v >>> 2;
        end
        return res;
    endfunction

    function automatic coord_t clamp_coord(input big_t v);
        coord_t r;
        if (v > big_t'(COORD_MAX)) begin
            r = COORD_MAX;
        end else if (v < big_t'(COORD_MIN)) begin
            r = COORD_MIN;
        end else begin
            r = v[COORD_BITS-1:0];
        end
        return r;
    endfunction

    function automatic res_t intersect_ray(input ray_t ray);
        res_t  res;
        big_t  d[3];
        big_t  o[3];
        big_t  a_sq;
        big_t  bh;
        big_t  cc;
        big_t  disc;
        big_t  root;
        big_t  numer;
        big_t  quot;
        big_t  hp;
        coord_t lam;
        a_sq = 0;
        bh = 0;
        cc = 0;
        for (int i = 0; i < 3; i++) begin
            d[i] = big_t'(ray.dir[i]);
            o[i] = big_t'(ray.eye[i]) - big_t'(ray.ctr[i]);
            a_sq += d[i] * d[i];
            bh += o[i] * d[i];
            cc += o[i] * o[i];
        end
        cc -= big_t'({1'b0, ray.radius}) * big_t'({1'b0, ray.radius});
        disc = bh * bh - a_sq * cc;
        res = '0;
        if (a_sq == 0 || disc < 0) begin
            res.lambda = MINUS_ONE;
            return res;
        end
        root = isqrt_floor(disc <<< (2 * FRAC_BITS));
        numer = -(bh <<< FRAC_BITS) - root;
        quot = numer / a_sq;
        if (numer < 0 && quot * a_sq != numer) quot = quot - 1;
        lam = clamp_coord(quot);
        res.hit = 1'b1;
        res.lambda = lam;
        hp = ((big_t'(lam) * d[0]) >>> FRAC_BITS) + o[0];
        res.hx = clamp_coord(hp);
        hp = ((big_t'(lam) * d[1]) >>> FRAC_BITS) + o[1];
        res.hy = clamp_coord(hp);
        hp = ((big_t'(lam) * d[2]) >>> FRAC_BITS) + o[2];
        res.hz = clamp_coord(hp);
        return res;
    endfunction

    // tvalid stays high after an accepted request; an idle gap or drain() drops it
    task automatic send_ray(input ray_t ray);
        logic [IN_DATA_W-1:0] word;
        word = '0;
        for (int i = 0; i < 3; i++) begin
            word[i*COORD_BITS +: COORD_BITS]       = ray.eye[i];
            word[(3+i)*COORD_BITS +: COORD_BITS]   = ray.dir[i];
            word[(6+i)*COORD_BITS +: COORD_BITS]   = ray.ctr[i];
        end
        word[9*COORD_BITS +: RADIUS_BITS] = ray.radius;
        while (src_idle_en && $urandom_range(99) < 8) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_hits.push_back(intersect_ray(ray));
        sent_count++;
    endtask

    function automatic coord_t rand_coord(input int span);
        coord_t v;
        case ($urandom_range(3))
            0: v = $urandom;
            1: v = $signed($urandom_range(2 * span)) - span;
            2: v = ($signed($urandom_range(64)) - 32) <<< FRAC_BITS;
            default: v = $signed($urandom_range(2000)) - 1000;
        endcase
        return v;
    endfunction

    // random ray aimed near the sphere so that most requests hit
    function automatic ray_t aimed_ray(input int span);
        ray_t r;
        for (int i = 0; i < 3; i++) begin
            r.ctr[i] = rand_coord(span);
            r.eye[i] = r.ctr[i] + rand_coord(span);
            r.dir[i] = -(r.eye[i] - r.ctr[i]) + ($signed($urandom_range(2 * span)) - span) / 4;
        end
        r.radius = RADIUS_BITS'($urandom_range(span));
        return r;
    endfunction

    function automatic ray_t noise_ray();
        ray_t r;
        for (int i = 0; i < 3; i++) begin
            r.eye[i] = $urandom;
            r.dir[i] = $urandom;
            r.ctr[i] = $urandom;
        end
        r.radius = RADIUS_BITS'($urandom);
        return r;
    endfunction

    task automatic test_directed();
        ray_t r;
        // eye on the axis, sphere at the origin, unit radius
        r.eye = '{coord_t'(-5 <<< FRAC_BITS), 0, 0};
        r.dir = '{coord_t'(1 <<< FRAC_BITS), 0, 0};
        r.ctr = '{0, 0, 0};
        r.radius = RADIUS_BITS'(1 <<< FRAC_BITS);
        send_ray(r);
        // tangent ray
        r.eye = '{coord_t'(-5 <<< FRAC_BITS), coord_t'(1 <<< FRAC_BITS), 0};
        send_ray(r);
        // miss
        r.eye[1] = 2 <<< FRAC_BITS;
        send_ray(r);
        // zero direction
        r.dir = '{0, 0, 0};
        send_ray(r);
        // sphere behind the eye
        r.eye = '{coord_t'(5 <<< FRAC_BITS), 0, 0};
        r.dir = '{coord_t'(1 <<< FRAC_BITS), 0, 0};
        send_ray(r);
        // eye inside the sphere
        r.eye = '{0, 0, 0};
        send_ray(r);
        // extremes of every field
        r.eye = '{COORD_MIN, COORD_MAX, COORD_MIN};
        r.ctr = '{COORD_MAX, COORD_MIN, COORD_MAX};
        r.dir = '{COORD_MAX, COORD_MIN, COORD_MAX};
        r.radius = '1;
        send_ray(r);
        r.radius = '0;
        send_ray(r);
        r.eye = '{COORD_MAX, COORD_MAX, COORD_MAX};
        r.ctr = r.eye;
        r.dir = '{COORD_MIN, COORD_MIN, COORD_MIN};
        r.radius = '1;
        send_ray(r);
        r.dir = '{1, 0, 0};
        send_ray(r);
        // tiny direction, huge radius: lambda saturates
        r.eye = '{COORD_MIN, 0, 0};
        r.ctr = '{COORD_MAX, 0, 0};
        send_ray(r);
        r.dir = '{-1, -1, -1};
        send_ray(r);
    endtask

    task automatic test_random(input int count);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(9) < 8)
                send_ray(aimed_ray($urandom_range(1) ? 32'h0010_0000 : 32'h4000_0000));
            else
                send_ray(noise_ray());
        end
    endtask

    // the sink holds off for a long stretch while the source keeps streaming
    task automatic test_backpressure(input int count);
        sink_hold = 3 * LATENCY;
        test_random(count);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_hits.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    // sink: random stalls, plus a counted long hold on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (sink_hold > 0) begin
            m_tready  <= 1'b0;
            sink_hold <= sink_hold - 1;
        end else begin
            m_tready <= !(sink_idle_en && $urandom_range(99) < 8);
        end
    end

    always @(posedge aclk) begin
        res_t exp_r;
        res_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.hit    = m_tuser;
            got.lambda = m_tdata[0 +: COORD_BITS];
            got.hx     = m_tdata[COORD_BITS +: COORD_BITS];
            got.hy     = m_tdata[2*COORD_BITS +: COORD_BITS];
            got.hz     = m_tdata[3*COORD_BITS +: COORD_BITS];
            recv_count++;
            if (pending_hits.size() == 0) begin
                $error("result with nothing expected: tdata=%h", m_tdata);
                fail_count++;
            end else begin
                exp_r = pending_hits.pop_front();
                hit_count += exp_r.hit;
                if (got.hit !== exp_r.hit) begin
                    $error("hit: expected %0d, got %0d", exp_r.hit, got.hit);
                    fail_count++;
                end
                if (got.lambda !== exp_r.lambda) begin
                    $error("lambda: expected %0d, got %0d", exp_r.lambda, got.lambda);
                    fail_count++;
                end
                if (got.hx !== exp_r.hx) begin
                    $error("hit_x: expected %0d, got %0d", exp_r.hx, got.hx);
                    fail_count++;
                end
                if (got.hy !== exp_r.hy) begin
                    $error("hit_y: expected %0d, got %0d", exp_r.hy, got.hy);
                    fail_count++;
                end
                if (got.hz !== exp_r.hz) begin
                    $error("hit_z: expected %0d, got %0d", exp_r.hz, got.hz);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("timeout with %0d requests outstanding", pending_hits.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        fail_count   = 0;
        sent_count   = 0;
        recv_count   = 0;
        hit_count    = 0;
        cycle_count  = 0;
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        sink_hold    = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random(300);
        // full-rate stretch
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        test_random(250);
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        test_backpressure(350);
        drain();

        $display("%0d rays sent, %0d results checked, %0d hits", sent_count, recv_count,
                 hit_count);
        $display("covered axis, tangent, miss, zero-direction, saturation and stall cases");
        if (fail_count == 0 && pending_hits.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/rsi_pkg.sv
hw/rtl/rsi_mul.sv
hw/rtl/rsi_sqrt.sv
hw/rtl/rsi_div.sv
hw/rtl/ray_sphere_intersect_core.sv
tb/sv/tb_ray_sphere_intersect_core.sv
